// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ===== rtl/rfg_pkg.sv =====
// ----------------------------------------------------------------------------
// rfg_pkg
// types, codes and constants of the rtu frame gap receiver
// ----------------------------------------------------------------------------
package rfg_pkg;

    localparam int FRAME_BYTES = 256;
    localparam int STORE_AW    = $clog2(FRAME_BYTES);
    localparam int COUNT_W     = 9;
    localparam int TICK_W      = 4;
    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    localparam logic [TICK_W-1:0] RST_INTERCHAR = 4'd3;
    localparam logic [TICK_W-1:0] RST_FRAME_GAP = 4'd7;

    typedef enum logic [0:0] {
        CFG_INTERCHAR = 1'b0,
        CFG_FRAME_GAP = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        FN_BYTE    = 2'd0,
        FN_TICK    = 2'd1,
        FN_RELEASE = 2'd2,
        FN_READ    = 2'd3
    } t_func;

    typedef enum logic [4:0] {
        ST_INIT = 5'b00001,
        ST_IDLE = 5'b00010,
        ST_RECV = 5'b00100,
        ST_GAP  = 5'b01000,
        ST_DONE = 5'b10000
    } t_state;

    localparam logic [2:0] CODE_INIT = 3'd0;
    localparam logic [2:0] CODE_IDLE = 3'd1;
    localparam logic [2:0] CODE_RECV = 3'd2;
    localparam logic [2:0] CODE_GAP  = 3'd3;
    localparam logic [2:0] CODE_DONE = 3'd4;

    typedef struct packed {
        t_func       func;
        logic [7:0]  data_byte;
        logic [7:0]  read_index;
    } t_req;

    typedef struct packed {
        logic [2:0]  state_code;
        logic        frame_ready;
        logic        frame_error;
        logic [8:0]  frame_length;
        logic [7:0]  read_data;
    } t_res;

    typedef struct packed {
        logic [2:0]         state_code;
        logic               frame_ready;
        logic               frame_error;
        logic [COUNT_W-1:0] frame_length;
    } t_status;

    typedef struct packed {
        logic                en;
        logic [STORE_AW-1:0] addr;
        logic [7:0]          data;
    } t_store_wr;

    function automatic logic [2:0] state_code(input t_state st);
        logic [2:0] code;
        unique case (st)
            ST_INIT: code = CODE_INIT;
            ST_IDLE: code = CODE_IDLE;
            ST_RECV: code = CODE_RECV;
            ST_GAP:  code = CODE_GAP;
            ST_DONE: code = CODE_DONE;
            default: code = CODE_INIT;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/rfg_req_if.sv =====
// ----------------------------------------------------------------------------
// rfg_req_if
// request channel: valid, ready and one request
// ----------------------------------------------------------------------------
interface rfg_req_if import rfg_pkg::*; ();

    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// ===== rtl/rfg_res_if.sv =====
// ----------------------------------------------------------------------------
// rfg_res_if
// result channel: valid, ready and one result
// ----------------------------------------------------------------------------
interface rfg_res_if import rfg_pkg::*; ();

    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// ===== rtl/rfg_ram.sv =====
// ----------------------------------------------------------------------------
// rfg_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module rfg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/rfg_ctrl.sv =====
// ----------------------------------------------------------------------------
// rfg_ctrl
// framing state machine, silence tick counter and frame store write control
// ----------------------------------------------------------------------------
module rfg_ctrl import rfg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [0:0]        i_cfg_idx,
    input  logic [TICK_W-1:0] i_cfg_wdata,
    input  logic              i_accept,
    input  t_req              i_req,
    output t_status           o_status,
    output t_store_wr         o_wr,
    output logic              o_rd_ok
);

    t_state             r_state,     n_state;
    logic [TICK_W-1:0]  r_sil,       n_sil;
    logic [COUNT_W-1:0] r_count,     n_count;
    logic               r_err,       n_err;
    logic               r_timer,     n_timer;
    logic [TICK_W-1:0]  r_interchar;
    logic [TICK_W-1:0]  r_gap;
    logic [TICK_W-1:0]  sil_inc;
    t_store_wr          wr;

    assign sil_inc = (r_sil == TICK_MAX) ? r_sil : r_sil + TICK_W'(1);

    always_comb begin
        n_state = r_state;
        n_sil   = r_sil;
        n_count = r_count;
        n_err   = r_err;
        n_timer = r_timer;
        wr      = '0;
        if (i_accept) begin
            unique case (i_req.func)
                FN_BYTE: begin
                    if (r_state == ST_INIT || r_state == ST_IDLE || r_state == ST_RECV) begin
                        n_sil   = '0;
                        n_state = ST_RECV;
                        if (r_count < COUNT_W'(FRAME_BYTES)) begin
                            wr.en   = 1'b1;
                            wr.addr = r_count[STORE_AW-1:0];
                            wr.data = i_req.data_byte;
                            n_count = r_count + COUNT_W'(1);
                        end
                    end else if (r_state == ST_GAP) begin
                        n_sil = '0;
                        n_err = 1'b1;
                    end
                    if (n_count == COUNT_W'(1)) begin
                        n_timer = 1'b1;
                    end
                end
                FN_TICK: begin
                    if (r_timer) begin
                        n_sil = sil_inc;
                        unique case (r_state)
                            ST_INIT: begin
                                if (sil_inc >= r_gap) begin
                                    n_sil   = '0;
                                    n_state = ST_IDLE;
                                end
                            end
                            ST_IDLE, ST_DONE: begin
                                n_sil = '0;
                            end
                            ST_RECV: begin
                                if (sil_inc >= r_interchar) begin
                                    n_state = ST_GAP;
                                end
                            end
                            ST_GAP: begin
                                if (sil_inc >= r_gap) begin
                                    n_timer = 1'b0;
                                    if (r_err) begin
                                        n_err   = 1'b0;
                                        n_sil   = '0;
                                        n_count = '0;
                                        n_state = ST_IDLE;
                                    end else begin
                                        n_state = ST_DONE;
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                FN_RELEASE: begin
                    if (r_state == ST_DONE) begin
                        n_err   = 1'b0;
                        n_sil   = '0;
                        n_count = '0;
                        n_state = ST_IDLE;
                    end
                end
                FN_READ: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_sil       <= '0;
            r_count     <= '0;
            r_err       <= 1'b0;
            r_timer     <= 1'b0;
            r_interchar <= RST_INTERCHAR;
            r_gap       <= RST_FRAME_GAP;
        end else begin
            r_state <= n_state;
            r_sil   <= n_sil;
            r_count <= n_count;
            r_err   <= n_err;
            r_timer <= n_timer;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_INTERCHAR: r_interchar <= i_cfg_wdata;
                    CFG_FRAME_GAP: r_gap       <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_status.state_code   = state_code(n_state);
    assign o_status.frame_ready  = (n_state == ST_DONE) && !n_err;
    assign o_status.frame_error  = n_err;
    assign o_status.frame_length = n_count;
    assign o_wr                  = wr;
    assign o_rd_ok = ({1'b0, i_req.read_index} < r_count)
                  && ({1'b0, i_req.read_index} < COUNT_W'(FRAME_BYTES));

endmodule

// ===== rtl/rtu_frame_gap_receiver.sv =====
// ----------------------------------------------------------------------------
// rtu_frame_gap_receiver
// frames rtu requests from received bytes and half-character timer ticks
// ----------------------------------------------------------------------------
// usage
//   i_req carries one request per handshake: a received byte, a timer tick,
//   a frame release or a read of a stored byte by position. o_res returns
//   exactly one result per request: state, ready and error flags, frame
//   length and, for reads, the stored byte (zero past the frame length).
//   i_cfg_we/i_cfg_idx/i_cfg_wdata write the inter-character and frame gap
//   tick counts; write them only while no request is in flight.
//   requests pass a middle stage, alongside the single-port write and
//   registered read of the 256-byte frame store, and one output register;
//   one request is taken every cycle while o_res is not stalled.
//   reset puts the framer in init with counters, flags and timer cleared
//   and restores the default tick counts; the store needs no clearing.
//   when o_res is stalled the output register holds, the middle stage
//   fills, and i_req.ready then drops until the result is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rtu_frame_gap_receiver import rfg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [0:0]        i_cfg_idx,
    input  logic [TICK_W-1:0] i_cfg_wdata,
    rfg_req_if.sink           i_req,
    rfg_res_if.source         o_res
);

    logic      accept;
    logic      s2_load;
    t_status   status;
    t_store_wr wr;
    logic      rd_ok;
    logic      rd_en;
    logic [7:0] ram_rdata;

    logic    r_s1_valid;
    t_status r_s1_status;
    logic    r_s1_rd;
    logic    r_s2_valid;
    t_res    r_s2_res;

    assign s2_load     = !r_s2_valid || o_res.ready;
    assign i_req.ready = !r_s1_valid || s2_load;
    assign accept      = i_req.valid && i_req.ready;
    assign rd_en       = accept && (i_req.data.func == FN_READ);

    rfg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_req       (i_req.data),
        .o_status    (status),
        .o_wr        (wr),
        .o_rd_ok     (rd_ok)
    );

    rfg_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr.en),
        .i_waddr (wr.addr),
        .i_wdata (wr.data),
        .i_re    (rd_en),
        .i_raddr (i_req.data.read_index[STORE_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (i_req.ready) begin
                r_s1_valid <= accept;
            end
            if (s2_load) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_status <= status;
            r_s1_rd     <= rd_en && rd_ok;
        end
        if (s2_load && r_s1_valid) begin
            r_s2_res.state_code   <= r_s1_status.state_code;
            r_s2_res.frame_ready  <= r_s1_status.frame_ready;
            r_s2_res.frame_error  <= r_s1_status.frame_error;
            r_s2_res.frame_length <= r_s1_status.frame_length;
            r_s2_res.read_data    <= r_s1_rd ? ram_rdata : 8'd0;
        end
    end

    assign o_res.valid = r_s2_valid;
    assign o_res.data  = r_s2_res;

    // read data must hold while the middle stage waits
    `ASSERT_CLK(a_rdata_held, i_clk, i_rst_n, (r_s1_valid && !s2_load) |=> $stable(ram_rdata))
    // no request may enter while the middle stage is stuck
    `ASSERT_NEVER(a_no_overrun, i_clk, i_rst_n, accept && r_s1_valid && !s2_load)
    // a frame is only ready in the finished state
    `ASSERT_NEVER(a_ready_done, i_clk, i_rst_n,
        o_res.valid && o_res.data.frame_ready && (o_res.data.state_code != CODE_DONE))
    // every store write leaves a non-empty frame
    `ASSERT_NEVER(a_wr_count, i_clk, i_rst_n, wr.en && (status.frame_length == '0))

endmodule

// ===== dv/rtu_frame_gap_receiver_tb.sv =====
// ----------------------------------------------------------------------------
// rtu_frame_gap_receiver_tb
// self-checking bench: directed walk through receive, gap check, error
// discard, finish and release, then random frames under several tick
// settings with noise, broken frames and a store overflow; a frame tracker
// predicts every result; both sides idle at random, the result side holds
// off once so the block backs up
// ----------------------------------------------------------------------------
module rtu_frame_gap_receiver_tb;
    import rfg_pkg::*;

    localparam int ITEMS = 1100;

    class frame_tracker;
        logic [TICK_W-1:0]  interchar;
        logic [TICK_W-1:0]  frame_gap;
        logic [2:0]         st;
        logic [TICK_W-1:0]  silence;
        logic [COUNT_W-1:0] count;
        logic               err;
        logic               timer_on;
        logic [7:0]         store [FRAME_BYTES];
        t_res               expected_res [$];
        int                 errors;

        function new();
            interchar = RST_INTERCHAR;
            frame_gap = RST_FRAME_GAP;
            st        = CODE_INIT;
            silence   = '0;
            count     = '0;
            err       = 1'b0;
            timer_on  = 1'b0;
            errors    = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [TICK_W-1:0] val);
            if (idx == CFG_INTERCHAR) begin
                interchar = val;
            end else begin
                frame_gap = val;
            end
        endfunction

        function void drop_frame();
            err     = 1'b0;
            silence = '0;
            count   = '0;
            st      = CODE_IDLE;
        endfunction

        function t_res advance(t_req r);
            t_res       res;
            logic [7:0] rd;
            rd = '0;
            case (r.func)
                FN_BYTE: begin
                    if (st == CODE_INIT || st == CODE_IDLE || st == CODE_RECV) begin
                        silence = '0;
                        st      = CODE_RECV;
                        if (count < FRAME_BYTES) begin
                            store[count[STORE_AW-1:0]] = r.data_byte;
                            count = count + 1'b1;
                        end
                    end else if (st == CODE_GAP) begin
                        silence = '0;
                        err     = 1'b1;
                    end
                    if (count == 1) timer_on = 1'b1;
                end
                FN_TICK: begin
                    if (timer_on) begin
                        if (silence != TICK_MAX) silence = silence + 1'b1;
                        case (st)
                            CODE_INIT: begin
                                if (silence >= frame_gap) begin
                                    silence = '0;
                                    st      = CODE_IDLE;
                                end
                            end
                            CODE_IDLE, CODE_DONE: silence = '0;
                            CODE_RECV: begin
                                if (silence >= interchar) st = CODE_GAP;
                            end
                            CODE_GAP: begin
                                if (silence >= frame_gap) begin
                                    if (err) drop_frame();
                                    else st = CODE_DONE;
                                    timer_on = 1'b0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                FN_RELEASE: begin
                    if (st == CODE_DONE) drop_frame();
                end
                default: begin
                    if (r.read_index < count) rd = store[r.read_index];
                end
            endcase
            res.state_code   = st;
            res.frame_ready  = (st == CODE_DONE) && !err;
            res.frame_error  = err;
            res.frame_length = count;
            res.read_data    = rd;
            return res;
        endfunction

        function void note_request(t_req r);
            expected_res.push_back(advance(r));
        endfunction

        function int pending();
            return expected_res.size();
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("mismatch: %s got %0d want %0d", what, got, want);
            errors++;
        endtask

        task check_result(t_res got);
            t_res want;
            if (expected_res.size() == 0) begin
                report_mismatch("result with no request pending", 0, 0);
            end else begin
                want = expected_res.pop_front();
                if (got.state_code !== want.state_code)
                    report_mismatch("state_code", int'(got.state_code),
                                    int'(want.state_code));
                if (got.frame_ready !== want.frame_ready)
                    report_mismatch("frame_ready", int'(got.frame_ready),
                                    int'(want.frame_ready));
                if (got.frame_error !== want.frame_error)
                    report_mismatch("frame_error", int'(got.frame_error),
                                    int'(want.frame_error));
                if (got.frame_length !== want.frame_length)
                    report_mismatch("frame_length", int'(got.frame_length),
                                    int'(want.frame_length));
                if (got.read_data !== want.read_data)
                    report_mismatch("read_data", int'(got.read_data),
                                    int'(want.read_data));
            end
        endtask
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    t_cfg_idx          i_cfg_idx;
    logic [TICK_W-1:0] i_cfg_wdata;

    rfg_req_if req_ch ();
    rfg_res_if res_ch ();

    rtu_frame_gap_receiver i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch),
        .o_res       (res_ch)
    );

    frame_tracker tracker;
    int           n_sent;
    int           frame_count;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    task automatic send_req(t_func f, logic [7:0] d, logic [7:0] ix);
        t_req r;
        r.func       = f;
        r.data_byte  = d;
        r.read_index = ix;
        if (n_sent < 600 || n_sent >= 750) begin
            while ($urandom_range(99) < 25) begin
                req_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        tracker.note_request(r);
        n_sent++;
    endtask

    task automatic send_ticks(int n);
        repeat (n) send_req(FN_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    task automatic send_byte(logic [7:0] d);
        send_req(FN_BYTE, d, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_read(int ix);
        send_req(FN_READ, 8'($urandom_range(0, 255)), (ix > 255) ? 8'd255 : ix[7:0]);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_ticks(logic [TICK_W-1:0] ic, logic [TICK_W-1:0] fg);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_INTERCHAR;
        i_cfg_wdata <= ic;
        @(posedge i_clk);
        tracker.set_reg(CFG_INTERCHAR, ic);
        i_cfg_idx   <= CFG_FRAME_GAP;
        i_cfg_wdata <= fg;
        @(posedge i_clk);
        tracker.set_reg(CFG_FRAME_GAP, fg);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic run_directed();
        send_req(FN_RELEASE, 8'h00, 8'h00);
        send_req(FN_TICK, 8'hFF, 8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_read(1);
        send_read(255);
        send_ticks(3);
        send_byte(8'hA5);
        send_ticks(7);
        send_byte(8'h5A);
        send_ticks(7);
        send_byte(8'h3C);
        send_req(FN_RELEASE, 8'h00, 8'h00);
        send_ticks(1);
    endtask

    task automatic run_frame();
        int len;
        int ic;
        int guard;
        frame_count++;
        if ($urandom_range(99) < 10) begin
            repeat ($urandom_range(1, 6)) begin
                send_req(t_func'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)));
            end
            return;
        end
        if (frame_count == 3) len = 260;
        else if ($urandom_range(99) < 2) len = $urandom_range(250, 270);
        else len = $urandom_range(1, 12);
        ic = (tracker.interchar > 1) ? tracker.interchar - 1 : 0;
        repeat (len) begin
            send_byte(8'($urandom_range(0, 255)));
            if ($urandom_range(99) < 15) send_read($urandom_range(0, tracker.count));
            if ($urandom_range(99) < 20) send_ticks($urandom_range(0, ic));
            if ($urandom_range(99) < 3) send_ticks($urandom_range(1, 16));
        end
        guard = 0;
        while (tracker.st == CODE_RECV && guard < 40) begin
            send_ticks(1);
            guard++;
        end
        if (tracker.st == CODE_GAP && $urandom_range(99) < 15) begin
            send_byte(8'($urandom_range(0, 255)));
        end
        guard = 0;
        while (tracker.st == CODE_GAP && guard < 40) begin
            send_ticks(1);
            guard++;
        end
        repeat ($urandom_range(0, 3)) send_read($urandom_range(0, tracker.count + 2));
        if ($urandom_range(99) < 90) send_req(FN_RELEASE, 8'($urandom_range(0, 255)),
                                              8'($urandom_range(0, 255)));
        if ($urandom_range(99) < 20) send_ticks($urandom_range(1, 2));
    endtask

    // result side: random stalls, one long hold-off, one steady stretch
    initial begin
        int hold;
        int seen;
        hold = 0;
        seen = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
                tracker.check_result(res_ch.data);
                seen++;
                if (seen == 460) hold = 150;
            end
            if (hold > 0) begin
                hold--;
                res_ch.ready <= 1'b0;
            end else if (seen >= 600 && seen < 750) begin
                res_ch.ready <= 1'b1;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= 25);
            end
        end
    end

    initial begin
        logic [TICK_W-1:0] ic_tab [8];
        logic [TICK_W-1:0] fg_tab [8];
        ic_tab = '{4'd3, 4'd1, 4'd15, 4'd0, 4'd15, 4'd1, 4'd2, 4'd0};
        fg_tab = '{4'd7, 4'd1, 4'd15, 4'd0, 4'd1, 4'd15, 4'd5, 4'd0};
        tracker      = new();
        n_sent       = 0;
        frame_count  = 0;
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= CFG_INTERCHAR;
        i_cfg_wdata  <= '0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        for (int p = 0; p < 8; p++) begin
            if (p > 0) begin
                wait_drained();
                if (p == 7) set_ticks(TICK_W'($urandom_range(0, 15)),
                                      TICK_W'($urandom_range(0, 15)));
                else set_ticks(ic_tab[p], fg_tab[p]);
            end
            while (n_sent < (p + 1) * ITEMS / 8) run_frame();
        end
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
